// ----- rtl/core/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by the cache top level and its checker.
package lkvc_pkg;

  // Field widths fixed by the stream format.
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // Default number of entries and the capacity after reset.
  localparam int          DEF_ENTRIES = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried in in_tuser.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  // Value returned by a get that misses.
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  // One request as held while it is worked on.
  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } lkvc_req_t;

endpackage

// ----- rtl/core/lkvc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used by the cache for its entry store.
module lkvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read, one of each per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg and on lkvc_ram for the entry store.

// The cache holds up to ENTRIES key/value pairs in one RAM, each word carrying
// key, value and a recency rank (0 is the most recently set). Valid bits and the
// used count sit in flip-flops and clear at reset; the RAM needs no clearing.
// Requests are handled one at a time. Every request scans all entries through
// the single RAM read port, one entry per cycle; a get then waits until the
// output register is free to take its result. A set adds a second pass that
// rewrites every entry with its new rank. A get returns one result transfer:
// found in out_tuser and the value, or all ones on a miss, in out_tdata. A set
// returns nothing. The next request is taken while a result still waits.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration: capacity.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CAP_W-1:0]       cfg_data,
  // Request stream.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [KEY_W+VAL_W-1:0] in_tdata,   // [31:0] key, [63:32] new_value
  input  logic                   in_tuser,   // [0] operation
  // Result stream.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [VAL_W-1:0]       out_tdata,  // [31:0] read_value
  output logic                   out_tuser   // [0] found
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int RANK_W = IDX_W;
  localparam int WORD_W = KEY_W + VAL_W + RANK_W;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Controller states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  lkvc_req_t          req_r, req_nxt;

  // Scan results.
  logic               hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [VAL_W-1:0]   hit_val_r, hit_val_nxt;
  logic [RANK_W-1:0]  hit_rank_r, hit_rank_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic               vic_found_r, vic_found_nxt;
  logic [IDX_W-1:0]   vic_idx_r, vic_idx_nxt;
  logic [RANK_W-1:0]  vic_rank_r, vic_rank_nxt;

  // Update pass controls.
  logic [IDX_W-1:0]   tgt_idx_r, tgt_idx_nxt;
  logic [RANK_W-1:0]  tgt_rank_r, tgt_rank_nxt;
  logic               inc_all_r, inc_all_nxt;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [VAL_W-1:0]   out_data_r, out_data_nxt;

  // RAM ports.
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [WORD_W-1:0]  rd_data;

  // Fields of the word returned by the RAM.
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;
  logic [RANK_W-1:0]  rd_rank;
  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   prev_idx;
  logic               cnt_last;
  logic               prev_valid;
  logic [CAP_W-1:0]   cap_eff;
  logic               room;

  assign rd_key   = rd_data[KEY_W-1:0];
  assign rd_val   = rd_data[KEY_W+VAL_W-1:KEY_W];
  assign rd_rank  = rd_data[WORD_W-1:KEY_W+VAL_W];
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign prev_idx = cnt_m1[IDX_W-1:0];
  assign cnt_last = (cnt_r == CNT_W'(ENTRIES));
  assign prev_valid = valid_r[prev_idx];

  // A capacity of zero behaves as one; a free slot means used is below ENTRIES.
  assign cap_eff = (cap_r == '0) ? CAP_W'(1) : cap_r;
  assign room    = free_found_r && (CMP_W'(used_r) < CMP_W'(cap_eff));

  // Both passes read entry cnt while the entry of the previous cycle is handled.
  assign rd_addr = cnt_last ? '0 : cnt_r[IDX_W-1:0];

  lkvc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Write-back of the update pass: new entry word at the target, aged or unchanged words elsewhere.
  always_comb begin
    wr_en   = (state_r == S_UPD) && (cnt_r != '0);
    wr_addr = prev_idx;
    if (prev_idx == tgt_idx_r) begin
      wr_data = {{RANK_W{1'b0}}, req_r.value, req_r.key};
    end else if (prev_valid && (inc_all_r || (rd_rank < tgt_rank_r))) begin
      wr_data = {rd_rank + RANK_W'(1), rd_val, rd_key};
    end else begin
      wr_data = rd_data;
    end
  end

  // Controller and scan bookkeeping.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    cap_nxt        = cap_r;
    req_nxt        = req_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_val_nxt    = hit_val_r;
    hit_rank_nxt   = hit_rank_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_rank_nxt   = vic_rank_r;
    tgt_idx_nxt    = tgt_idx_r;
    tgt_rank_nxt   = tgt_rank_r;
    inc_all_nxt    = inc_all_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_data_nxt   = out_data_r;

    // Configuration transfer.
    if (cfg_valid) begin
      cap_nxt = cfg_data;
    end

    // Result transfer frees the output register.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt.op     = in_tuser;
          req_nxt.key    = in_tdata[KEY_W-1:0];
          req_nxt.value  = in_tdata[KEY_W+VAL_W-1:KEY_W];
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          vic_found_nxt  = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // Look at the entry read in the previous cycle.
        if (cnt_r != '0) begin
          if (prev_valid && (rd_key == req_r.key) && !hit_found_r) begin
            hit_found_nxt = 1'b1;
            hit_idx_nxt   = prev_idx;
            hit_val_nxt   = rd_val;
            hit_rank_nxt  = rd_rank;
          end
          if (!prev_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = prev_idx;
          end
          if (prev_valid && (!vic_found_r || (rd_rank > vic_rank_r))) begin
            vic_found_nxt = 1'b1;
            vic_idx_nxt   = prev_idx;
            vic_rank_nxt  = rd_rank;
          end
        end
        if (cnt_last) begin
          state_nxt = S_DEC;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DEC: begin
        // Pick the slot a set writes and how the other ranks move.
        cnt_nxt = '0;
        if (req_r.op == OP_GET) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_UPD;
          if (hit_found_r) begin
            tgt_idx_nxt  = hit_idx_r;
            tgt_rank_nxt = hit_rank_r;
            inc_all_nxt  = 1'b0;
          end else if (room) begin
            tgt_idx_nxt  = free_idx_r;
            tgt_rank_nxt = '0;
            inc_all_nxt  = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
            used_nxt     = used_r + CNT_W'(1);
          end else begin
            tgt_idx_nxt  = vic_idx_r;
            tgt_rank_nxt = vic_rank_r;
            inc_all_nxt  = 1'b0;
          end
        end
      end
      S_UPD: begin
        if (cnt_last) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_OUT: begin
        // Load the result once the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_found_r;
          out_data_nxt  = hit_found_r ? hit_val_r : MISS_VALUE;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state is reset; payload registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      used_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_val_r    <= hit_val_nxt;
    hit_rank_r   <= hit_rank_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    vic_found_r  <= vic_found_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_rank_r   <= vic_rank_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    tgt_rank_r   <= tgt_rank_nxt;
    inc_all_r    <= inc_all_nxt;
    out_found_r  <= out_found_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule

// ----- rtl/core/lkvc_checker.sv -----
// Port-level checker for the LRU key-value cache, bound to its top level.
// Depends on lkvc_pkg and on the port list of lru_key_value_cache.
module lkvc_checker
  import lkvc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [VAL_W-1:0]       out_tdata,
  input logic                   out_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A miss always carries the all-ones value.
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == MISS_VALUE)
    else $error("miss result without all-ones value");

  // A request keeps the input not ready through the start of its scan.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("request accepted during a scan");

  // A new result appears only as a request finishes.
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result produced while idle");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// ----- sim/lru_key_value_cache_tb.sv -----
// Self-checking testbench for the LRU key-value cache (lru_key_value_cache).
// Depends on lkvc_pkg and the cache RTL; it drives directed and random requests and
// checks every result against the planned value or else a cycle-free predictor.
module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int ENTRIES = DEF_ENTRIES;
  // Cycles to let a set finish its rewrite pass before a capacity write.
  localparam int SETTLE = 2 * ENTRIES + 20;
  // Idle cycles without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Length of the long output hold-off.
  localparam int HOLD_CYCLES = 400;
  localparam int CHUNKS = 6;
  localparam int CHUNK_ITEMS = 142;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } lookup_result_t;

  typedef enum logic [1:0] {ROW_GET, ROW_SET, ROW_CAPACITY} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    logic             exp_found;
    logic [VAL_W-1:0] exp_value;
  } plan_row_t;

  // Directed requests. Capacity rows carry the new capacity in the value column.
  // Typed rows carry the expected result; the rest are predicted.
  localparam int PLAN_ROWS = 23;
  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_GET,      32'h0000_0000, 32'h1234_5678, 1'b1, 1'b0, MISS_VALUE},
    '{ROW_GET,      32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE},
    '{ROW_SET,      32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SET,      32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_SET,      32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // Capacity lowered below the used count: the oldest entry gets replaced.
    '{ROW_CAPACITY, 32'h0,         32'd1,         1'b0, 1'b0, 32'h0},
    '{ROW_SET,      32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // A capacity of zero behaves as one.
    '{ROW_CAPACITY, 32'h0,         32'd0,         1'b0, 1'b0, 32'h0},
    '{ROW_SET,      32'h0000_0006, 32'h0000_0006, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h0000_0006, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    // A capacity above the entry count behaves as the entry count.
    '{ROW_CAPACITY, 32'h0,         32'd31,        1'b0, 1'b0, 32'h0},
    '{ROW_SET,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_SET,      32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_GET,      32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_CAPACITY, 32'h0,         32'd16,        1'b0, 1'b0, 32'h0}
  };

  // Capacity used by each random chunk, extremes included.
  int chunk_capacity [CHUNKS] = '{31, 1, 9, 0, 16, 4};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [KEY_W+VAL_W-1:0] in_tdata = '0;   // [31:0] key, [63:32] new_value
  logic                   in_tuser = 1'b0; // [0] operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [VAL_W-1:0]       out_tdata;       // [31:0] read_value
  logic                   out_tuser;       // [0] found

  // Expected result that travels alongside a typed directed request.
  logic           req_typed = 1'b0;
  lookup_result_t req_expected = '0;

  // Predictor state: a software copy of the cache contents.
  logic [KEY_W-1:0] slot_key   [ENTRIES];
  logic [VAL_W-1:0] slot_value [ENTRIES];
  bit               slot_valid [ENTRIES];
  int               slot_rank  [ENTRIES];
  int               slots_used = 0;
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;

  lookup_result_t pending_lookups [$];
  int errors = 0;
  int requests_sent = 0;
  int lookups_checked = 0;
  int in_xfers = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_at = 32'h7FFF_FFFF;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // Move slot s to the front: every valid entry newer than it ages by one.
  function automatic void make_newest(input int s);
    int r;
    r = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != s && slot_valid[i] && slot_rank[i] < r) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  // Apply one request to the predicted cache. Returns 1 when it yields a result.
  function automatic bit apply_request(input logic op, input logic [KEY_W-1:0] key,
                                       input logic [VAL_W-1:0] value,
                                       output lookup_result_t res);
    int hit;
    int free_slot;
    int victim;
    int limit;
    hit = -1;
    free_slot = -1;
    victim = -1;
    res = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
    end
    if (op == OP_GET) begin
      if (hit >= 0) res = lookup_result_t'{found: 1'b1, value: slot_value[hit]};
      else res = lookup_result_t'{found: 1'b0, value: MISS_VALUE};
      return 1'b1;
    end
    // A set to a stored key updates it in place.
    if (hit >= 0) begin
      slot_value[hit] = value;
      make_newest(hit);
      return 1'b0;
    end
    limit = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
    if (slots_used < limit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_slot < 0 && !slot_valid[i]) free_slot = i;
      end
    end
    if (free_slot >= 0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i]) slot_rank[i]++;
      end
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot] = key;
      slot_value[free_slot] = value;
      slot_rank[free_slot] = 0;
      slots_used++;
      return 1'b0;
    end
    // Otherwise the oldest valid entry is replaced, lowest index on a tie.
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
    end
    if (victim >= 0) begin
      slot_key[victim] = key;
      slot_value[victim] = value;
      make_newest(victim);
    end
    return 1'b0;
  endfunction

  // Predict on every request transfer and check every result transfer.
  always @(posedge clk) begin : check_stream
    lookup_result_t predicted;
    lookup_result_t oldest;
    bit has_result;
    if (rst_n) begin
      // The result side is handled first so a same-edge request cannot match it.
      if (out_tvalid && out_tready) begin
        if (pending_lookups.size() == 0) begin
          $error("unexpected result: found=%0b value=%h", out_tuser, out_tdata);
          errors++;
        end else begin
          oldest = pending_lookups.pop_front();
          if (out_tuser !== oldest.found) begin
            $error("found: expected %0b, got %0b", oldest.found, out_tuser);
            errors++;
          end
          if (out_tdata !== oldest.value) begin
            $error("read_value: expected %h, got %h", oldest.value, out_tdata);
            errors++;
          end
          lookups_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        has_result = apply_request(in_tuser, in_tdata[KEY_W-1:0],
                                   in_tdata[KEY_W+VAL_W-1:KEY_W], predicted);
        if (has_result) pending_lookups.push_back(req_typed ? req_expected : predicted);
        in_xfers <= in_xfers + 1;
      end
      if (cfg_valid && cfg_ready) capacity_reg = cfg_data;
    end
  end

  // Result side: random stalls, plus one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_xfers >= hold_at) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, with random gaps before it, and wait for its transfer.
  task automatic offer_request(input logic op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] value, input logic typed,
                               input lookup_result_t expected_res);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {value, key};
    req_typed <= typed;
    req_expected <= expected_res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Drain all results, let any set finish, then write the capacity register.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    in_tvalid <= 1'b0;
    // Step past the next edge first, so the last request is already in the expected queue.
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool [ENTRIES + 4];
    int pool_n;
    logic [KEY_W-1:0] key;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_valid[i] = 1'b0;
      slot_rank[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the sender idling lightly and the receiver heavily.
    tx_idle_pct = 21;
    rx_idle_pct = 73;
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CAPACITY)
        set_capacity(plan[r].value[CAP_W-1:0]);
      else
        offer_request((plan[r].kind == ROW_SET) ? OP_SET : OP_GET, plan[r].key,
                      plan[r].value, plan[r].typed,
                      lookup_result_t'{found: plan[r].exp_found, value: plan[r].exp_value});
    end

    // Random part: keys mostly from a small pool sized to the capacity, so hits,
    // fills, updates and evictions all happen; some fully random keys as noise.
    for (int c = 0; c < CHUNKS; c++) begin
      set_capacity(chunk_capacity[c][CAP_W-1:0]);
      case (c / 2)
        0: begin tx_idle_pct = 21; rx_idle_pct = 73; end
        1: begin tx_idle_pct = 73; rx_idle_pct = 21; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      if (c == 1) hold_at = in_xfers + 40;
      pool_n = (chunk_capacity[c] == 0) ? 5 :
               (chunk_capacity[c] > ENTRIES) ? ENTRIES + 4 : chunk_capacity[c] + 4;
      for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom;
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(pool_n - 1)] : $urandom;
        offer_request($urandom_range(1) ? OP_SET : OP_GET, key, $urandom, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      $error("%0d expected results never arrived", pending_lookups.size());
      errors++;
    end
    $display("Sent %0d requests and checked %0d lookups over capacities 0 to 31,",
             requests_sent, lookups_checked);
    $display("with fills, in-place updates, evictions and a long output stall.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_ram.sv
rtl/core/lru_key_value_cache.sv
rtl/core/lkvc_checker.sv
sim/lru_key_value_cache_tb.sv
